// File: rtl/qpr_pkg.sv
// Shared types, widths and rounding helper for the quaternion product / rotate core.
// Used by every module of the core; depends on nothing.
`default_nettype none

package qpr_pkg;

  localparam int unsigned COMP_WIDTH = 16;
  localparam int unsigned FRAC_BITS  = 14;
  // sign-extended multiplicand for the conjugate pass keeps -min exact
  localparam int unsigned PROD_WIDTH = 2 * COMP_WIDTH + 1;
  localparam int unsigned SUM_WIDTH  = PROD_WIDTH + 2;
  localparam int unsigned LATENCY    = 4;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [COMP_WIDTH:0]   ext_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [SUM_WIDTH-1:0]  sum_t;

  typedef struct packed {
    logic  req_type;
    comp_t a_w;
    comp_t a_x;
    comp_t a_y;
    comp_t a_z;
    comp_t b_w;
    comp_t b_x;
    comp_t b_y;
    comp_t b_z;
  } req_t;

  typedef struct packed {
    comp_t res_w;
    comp_t res_x;
    comp_t res_y;
    comp_t res_z;
    logic  saturated;
  } res_t;

  typedef struct packed {
    comp_t val;
    logic  clamp;
  } sat_t;

  // Term r*4+k of the Hamilton product is subtracted when its bit is set
  localparam logic [15:0] NEG_TERM = 16'h428E;

  localparam comp_t COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};
  localparam sum_t  SUM_HI   = {{(SUM_WIDTH-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
  localparam sum_t  SUM_LO   = {{(SUM_WIDTH-COMP_WIDTH+1){1'b1}}, {(COMP_WIDTH-1){1'b0}}};
  localparam sum_t  SUM_HALF = sum_t'(1) <<< (FRAC_BITS - 1);

  // Round to nearest, ties upward, then clamp to the component range
  function automatic sat_t round_sat(sum_t s);
    sum_t sh;
    sat_t r;
    sh = (s + SUM_HALF) >>> FRAC_BITS;
    priority if (sh > SUM_HI) begin
      r.val   = COMP_MAX;
      r.clamp = 1'b1;
    end else if (sh < SUM_LO) begin
      r.val   = COMP_MIN;
      r.clamp = 1'b1;
    end else begin
      r.val   = sh[COMP_WIDTH-1:0];
      r.clamp = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/qpr_mul.sv
// Product stage: the sixteen exact partial products of one Hamilton product, registered.
// Depends on qpr_pkg.
`default_nettype none

module qpr_mul import qpr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  comp_t p_i [4],
  input  ext_t  q_i [4],
  output logic  valid_o,
  output prod_t prod_o [4][4]
);

  logic  valid_q;
  prod_t prod_d [4][4];
  prod_t prod_q [4][4];

  // row r, column k pairs p[k] with q[r xor k]
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 4; k++) begin
        prod_d[r][k] = prod_t'(p_i[k]) * prod_t'(q_i[r ^ k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

// File: rtl/qpr_sum.sv
// Sum stage: signed four-term sums per component, rounded and clamped, registered.
// Depends on qpr_pkg.
`default_nettype none

module qpr_sum import qpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  prod_t      prod_i [4][4],
  output logic       valid_o,
  output comp_t      res_o [4],
  output logic [3:0] clamp_o
);

  logic       valid_q;
  comp_t      res_d [4];
  comp_t      res_q [4];
  logic [3:0] clamp_d;
  logic [3:0] clamp_q;

  always_comb begin
    sum_t acc;
    sum_t term;
    sat_t sat;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        term = sum_t'(prod_i[r][k]);
        acc  = NEG_TERM[r*4+k] ? acc - term : acc + term;
      end
      sat        = round_sat(acc);
      res_d[r]   = sat.val;
      clamp_d[r] = sat.clamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    clamp_q <= clamp_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign clamp_o = clamp_q;

endmodule

`default_nettype wire

// File: rtl/quaternion_product_rotate_core.sv
// Top level of the quaternion product / vector rotation core.
// Depends on qpr_pkg, qpr_mul and qpr_sum.
//
// Takes one word per clock: busy is never raised, so a word is taken at every edge with
// start high. Each result appears on res_o for one cycle with done_o high, in the order
// its words were taken; the receiver cannot hold it off. The pipeline is
// two product passes, each a register of sixteen partial products followed by
// a register of rounded, clamped sums: pass one forms A*B (or A*(0,B)), pass two forms
// T*conj(A) for rotation. A product request carries the pass-one result past pass two.
`default_nettype none

module quaternion_product_rotate_core import qpr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  logic       accept;
  comp_t      p1 [4];
  ext_t       q1 [4];
  logic       v1, v2, v3, v4;
  prod_t      prod1 [4][4];
  prod_t      prod2 [4][4];
  comp_t      t_val [4];
  logic [3:0] clamp1;
  ext_t       q2 [4];
  comp_t      r_val [4];
  logic [3:0] clamp2;

  // side band travelling alongside the arithmetic
  logic  s1_rot_q, s2_rot_q, s3_rot_q, s4_rot_q;
  comp_t s1_a_q [4];
  comp_t s2_a_q [4];
  comp_t s3_t_q [4];
  comp_t s4_t_q [4];
  logic  s3_sat_q, s4_sat_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign p1[0] = req_i.a_w;
  assign p1[1] = req_i.a_x;
  assign p1[2] = req_i.a_y;
  assign p1[3] = req_i.a_z;
  // drop the scalar part of B when rotating
  assign q1[0] = req_i.req_type ? ext_t'(0) : ext_t'(req_i.b_w);
  assign q1[1] = ext_t'(req_i.b_x);
  assign q1[2] = ext_t'(req_i.b_y);
  assign q1[3] = ext_t'(req_i.b_z);

  qpr_mul u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .p_i     (p1),
    .q_i     (q1),
    .valid_o (v1),
    .prod_o  (prod1)
  );

  qpr_sum u_sum1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .prod_i  (prod1),
    .valid_o (v2),
    .res_o   (t_val),
    .clamp_o (clamp1)
  );

  // conjugate of A, one bit wider so the most negative value negates exactly
  assign q2[0] = ext_t'(s2_a_q[0]);
  assign q2[1] = -ext_t'(s2_a_q[1]);
  assign q2[2] = -ext_t'(s2_a_q[2]);
  assign q2[3] = -ext_t'(s2_a_q[3]);

  qpr_mul u_mul2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .p_i     (t_val),
    .q_i     (q2),
    .valid_o (v3),
    .prod_o  (prod2)
  );

  qpr_sum u_sum2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .prod_i  (prod2),
    .valid_o (v4),
    .res_o   (r_val),
    .clamp_o (clamp2)
  );

  always_ff @(posedge clk_i) begin
    s1_rot_q <= req_i.req_type;
    s1_a_q   <= p1;
    s2_rot_q <= s1_rot_q;
    s2_a_q   <= s1_a_q;
    s3_rot_q <= s2_rot_q;
    s3_t_q   <= t_val;
    s3_sat_q <= |clamp1;
    s4_rot_q <= s3_rot_q;
    s4_t_q   <= s3_t_q;
    s4_sat_q <= s3_sat_q;
  end

  assign done_o = v4;

  always_comb begin
    if (s4_rot_q) begin
      res_o.res_w     = '0;
      res_o.res_x     = r_val[1];
      res_o.res_y     = r_val[2];
      res_o.res_z     = r_val[3];
      res_o.saturated = s4_sat_q || (|clamp2[3:1]);
    end else begin
      res_o.res_w     = s4_t_q[0];
      res_o.res_x     = s4_t_q[1];
      res_o.res_y     = s4_t_q[2];
      res_o.res_z     = s4_t_q[3];
      res_o.saturated = s4_sat_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/qpr_checker.sv
// Port-level checks on the quaternion product / rotate core, bound to its top level.
// Depends on qpr_pkg and quaternion_product_rotate_core.
`default_nettype none

module qpr_checker import qpr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input res_t res_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised although the core takes a word every cycle");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY done_o)
    else $error("accepted word produced no result after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching accepted word");

  a_rot_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(start && !busy && req_i.req_type, LATENCY) |-> res_o.res_w == '0)
    else $error("rotation result carries a non-zero scalar part");

endmodule

bind quaternion_product_rotate_core qpr_checker u_qpr_checker (.*);

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for quaternion_product_rotate_core: Hamilton products and vector rotations.
// Predicts each result at the accepting edge and checks it in order; needs qpr_pkg and the RTL.

module tb;
  import qpr_pkg::*;

  localparam bit OP_PRODUCT = 1'b0;
  localparam bit OP_ROTATE  = 1'b1;
  localparam int MAX_GAP    = 10;
  localparam int N_RANDOM   = 1250;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_word;
  logic done_o;
  res_t res_word;

  req_t words_to_send[$];
  res_t results_due[$];
  logic word_taken;
  int   idle_left;
  bit   burst;
  int   mismatches;

  quaternion_product_rotate_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_word),
    .done_o (done_o),
    .res_o  (res_word)
  );

  always #5 clk_i = ~clk_i;

  // Round to nearest with ties upward, then clamp to the component range
  function automatic longint round_clamp(input longint s, output bit clamped);
    longint v;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
    lo = -hi - 1;
    v  = (s + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    clamped = 1'b0;
    if (v > hi) begin
      clamped = 1'b1;
      v = hi;
    end else if (v < lo) begin
      clamped = 1'b1;
      v = lo;
    end
    return v;
  endfunction

  function automatic void hamilton(input longint p0, p1, p2, p3, q0, q1, q2, q3,
                                   output longint r0, r1, r2, r3, output bit [3:0] clamp);
    r0 = round_clamp(p0*q0 - p1*q1 - p2*q2 - p3*q3, clamp[0]);
    r1 = round_clamp(p0*q1 + p1*q0 + p2*q3 - p3*q2, clamp[1]);
    r2 = round_clamp(p0*q2 - p1*q3 + p2*q0 + p3*q1, clamp[2]);
    r3 = round_clamp(p0*q3 + p1*q2 - p2*q1 + p3*q0, clamp[3]);
  endfunction

  function automatic res_t product_or_rotation(input req_t w);
    longint a0, a1, a2, a3, b0, b1, b2, b3;
    longint t0, t1, t2, t3, r0, r1, r2, r3;
    bit [3:0] c1;
    bit [3:0] c2;
    res_t r;
    a0 = w.a_w; a1 = w.a_x; a2 = w.a_y; a3 = w.a_z;
    b0 = w.b_w; b1 = w.b_x; b2 = w.b_y; b3 = w.b_z;
    if (w.req_type == OP_PRODUCT) begin
      hamilton(a0, a1, a2, a3, b0, b1, b2, b3, r0, r1, r2, r3, c1);
      r.saturated = |c1;
    end else begin
      // the conjugate keeps a negated minimum exact; the w part of pass two is dropped
      hamilton(a0, a1, a2, a3, 0, b1, b2, b3, t0, t1, t2, t3, c1);
      hamilton(t0, t1, t2, t3, a0, -a1, -a2, -a3, r0, r1, r2, r3, c2);
      r0 = 0;
      r.saturated = (|c1) | (|c2[3:1]);
    end
    r.res_w = comp_t'(r0);
    r.res_x = comp_t'(r1);
    r.res_y = comp_t'(r2);
    r.res_z = comp_t'(r3);
    return r;
  endfunction

  function automatic req_t make_word(input bit op, input int aw, ax, ay, az, bw, bx, by, bz);
    req_t w;
    w.req_type = op;
    w.a_w = comp_t'(aw); w.a_x = comp_t'(ax); w.a_y = comp_t'(ay); w.a_z = comp_t'(az);
    w.b_w = comp_t'(bw); w.b_x = comp_t'(bx); w.b_y = comp_t'(by); w.b_z = comp_t'(bz);
    return w;
  endfunction

  function automatic comp_t rand_comp();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 11) return comp_t'($urandom);
    if (sel < 17) return comp_t'(int'($urandom_range(0, 32768)) - 16384);
    case ($urandom_range(0, 6))
      0: return COMP_MIN;
      1: return COMP_MAX;
      2: return comp_t'(0);
      3: return comp_t'(1);
      4: return comp_t'(-1);
      5: return comp_t'(16384);
      default: return comp_t'(-16384);
    endcase
  endfunction

  function automatic req_t rand_word();
    req_t w;
    w.req_type = $urandom_range(0, 1) ? OP_ROTATE : OP_PRODUCT;
    w.a_w = rand_comp(); w.a_x = rand_comp(); w.a_y = rand_comp(); w.a_z = rand_comp();
    w.b_w = rand_comp(); w.b_x = rand_comp(); w.b_y = rand_comp(); w.b_z = rand_comp();
    return w;
  endfunction

  // Record each accepted word and predict its result
  always @(posedge clk_i) begin
    word_taken <= rst_ni && start && !busy;
    if (rst_ni && start && !busy)
      results_due.push_back(product_or_rotation(req_word));
  end

  // Present the next word after its drawn gap; hold it until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!start || word_taken)) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (words_to_send.size() != 0) begin
        req_word <= words_to_send.pop_front();
        start <= 1'b1;
        if ($urandom_range(0, 39) == 0) burst <= !burst;
        idle_left <= burst ? 0 : $urandom_range(0, MAX_GAP);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result w=%0d x=%0d y=%0d z=%0d sat=%0b", res_word.res_w,
                   res_word.res_x, res_word.res_y, res_word.res_z, res_word.saturated);
      end else begin
        res_t exp_res;
        exp_res = results_due.pop_front();
        if (res_word.res_w !== exp_res.res_w || res_word.res_x !== exp_res.res_x ||
            res_word.res_y !== exp_res.res_y || res_word.res_z !== exp_res.res_z ||
            res_word.saturated !== exp_res.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d sat=%0b, got w=%0d x=%0d y=%0d z=%0d sat=%0b",
                     exp_res.res_w, exp_res.res_x, exp_res.res_y, exp_res.res_z,
                     exp_res.saturated, res_word.res_w, res_word.res_x, res_word.res_y,
                     res_word.res_z, res_word.saturated);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_word   = '0;
    idle_left  = 0;
    burst      = 1'b0;
    mismatches = 0;

    words_to_send.push_back(make_word(OP_PRODUCT, 16384, 0, 0, 0, 16384, 0, 0, 0));
    words_to_send.push_back(make_word(OP_PRODUCT, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767));
    words_to_send.push_back(make_word(OP_PRODUCT, -32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768));
    words_to_send.push_back(make_word(OP_PRODUCT, 32767, 32767, 32767, 32767,
                                      -32768, -32768, -32768, -32768));
    words_to_send.push_back(make_word(OP_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0));
    // exact halves: a positive tie rounds up, a negative one rounds towards zero
    words_to_send.push_back(make_word(OP_PRODUCT, 1, 0, 0, 0, 8192, 0, 0, 0));
    words_to_send.push_back(make_word(OP_PRODUCT, -1, 0, 0, 0, 8192, 0, 0, 0));
    words_to_send.push_back(make_word(OP_PRODUCT, 0, 16384, 0, 0, 0, 0, 16384, 0));
    words_to_send.push_back(make_word(OP_PRODUCT, 32767, -32768, 32767, -32768,
                                      -32768, -32768, 32767, 32767));
    words_to_send.push_back(make_word(OP_PRODUCT, -32768, 0, 0, 0, -32768, 0, 0, 0));
    words_to_send.push_back(make_word(OP_ROTATE, 16384, 0, 0, 0, 32767, 16384, -16384, 8192));
    words_to_send.push_back(make_word(OP_ROTATE, 0, 0, 0, 16384, 0, 16384, 0, 0));
    words_to_send.push_back(make_word(OP_ROTATE, -32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768));
    words_to_send.push_back(make_word(OP_ROTATE, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767));
    words_to_send.push_back(make_word(OP_ROTATE, 11585, 11585, 0, 0, 0, 0, 16384, 0));
    words_to_send.push_back(make_word(OP_ROTATE, 0, 0, 0, 0, 1, 32767, -32768, 5));
    words_to_send.push_back(make_word(OP_ROTATE, -32768, -32768, -32768, -32768,
                                      -32768, 32767, 32767, 32767));
    words_to_send.push_back(make_word(OP_ROTATE, 16384, 0, 0, 0, -1, -1, 1, -32768));
    words_to_send.push_back(make_word(OP_ROTATE, 0, -32768, 0, 0, 0, 0, 32767, -32768));
    words_to_send.push_back(make_word(OP_ROTATE, 1, -1, 1, -1, 0, 8192, -8192, 8191));
    for (int i = 0; i < N_RANDOM; i++)
      words_to_send.push_back(rand_word());

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (words_to_send.size() != 0 || start) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
rtl/qpr_pkg.sv
rtl/qpr_mul.sv
rtl/qpr_sum.sv
rtl/quaternion_product_rotate_core.sv
rtl/qpr_checker.sv
sim/tb.sv
